// ----- rtl/rgbc3_pkg.sv -----
// Shared types and constants for the 3x3 RGB convolution filter.
// Used by rgbc3_line_mem, rgbc3_filter and rgb_conv3x3_zero_pad_core.
package rgbc3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int LINE_AW    = $clog2(MAX_WIDTH);
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd640;
    localparam logic [15:0] RST_IMAGE_HEIGHT  = 16'd480;
    localparam logic [23:0] RST_KERNEL_TOP    = 24'h000000;
    localparam logic [23:0] RST_KERNEL_MIDDLE = 24'h004000;
    localparam logic [23:0] RST_KERNEL_BOTTOM = 24'h000000;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } t_cfg_idx;

    // Pixel word: red in bits 7:0, green in 15:8, blue in 23:16.
    typedef logic [23:0] t_pix;

    // Window row 0 is the row above, column 0 the left neighbor.
    typedef t_pix [2:0][2:0] t_window;

    // Kernel row 0 is the top row; byte 0 of a row is its left coefficient.
    typedef logic [2:0][23:0] t_kernel;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edge;

    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_line_word;

    typedef struct packed {
        logic       kind;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_out_beat;

endpackage

// ----- rtl/rgbc3_line_mem.sv -----
// Two-row line store for the 3x3 filter: one word per column holds both rows.
// Registered read with forwarding of the write made at the read edge.
// Depends on rgbc3_pkg.
module rgbc3_line_mem (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [rgbc3_pkg::LINE_AW-1:0]     i_rd_addr,
    input  logic                              i_wr_en,
    input  logic [rgbc3_pkg::LINE_AW-1:0]     i_wr_addr,
    input  rgbc3_pkg::t_line_word             i_wr_data,
    output rgbc3_pkg::t_line_word             o_rd_data
);

    rgbc3_pkg::t_line_word r_mem [rgbc3_pkg::MAX_WIDTH];
    rgbc3_pkg::t_line_word r_rd_q;
    rgbc3_pkg::t_line_word r_byp_data;
    logic [rgbc3_pkg::LINE_AW-1:0] r_rd_addr;
    logic [rgbc3_pkg::LINE_AW-1:0] r_byp_addr;
    logic                          r_byp_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_q     <= r_mem[i_rd_addr];
        r_rd_addr  <= i_rd_addr;
        r_byp_addr <= i_wr_addr;
        r_byp_data <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_vld <= 1'b0;
        end else begin
            r_byp_vld <= i_wr_en;
        end
    end

    assign o_rd_data = (r_byp_vld && (r_byp_addr == r_rd_addr)) ? r_byp_data : r_rd_q;

endmodule

// ----- rtl/rgbc3_filter.sv -----
// Per-channel 3x3 multiply stage (registered products) and sum, shift and clamp.
// Depends on rgbc3_pkg.
module rgbc3_filter (
    input  logic                 i_clk,
    input  rgbc3_pkg::t_window   i_win,
    input  rgbc3_pkg::t_kernel   i_kern,
    input  rgbc3_pkg::t_edge     i_edge,
    output logic [2:0][7:0]      o_chan
);

    logic               en    [3][3];
    logic signed [16:0] coef  [3][3];
    logic signed [16:0] pval  [3][3][3];
    logic signed [16:0] n_prod [3][3][3];
    logic signed [16:0] r_prod [3][3][3];
    logic signed [20:0] acc   [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                en[r][c] = 1'b1;
                if (r == 0) en[r][c] = en[r][c] & i_edge.top;
                if (r == 2) en[r][c] = en[r][c] & i_edge.bottom;
                if (c == 0) en[r][c] = en[r][c] & i_edge.left;
                if (c == 2) en[r][c] = en[r][c] & i_edge.right;
                coef[r][c] = 17'($signed(i_kern[r][8*c +: 8]));
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    pval[ch][r][c] = $signed({9'd0, i_win[r][c][8*ch +: 8]});
                    n_prod[ch][r][c] = en[r][c] ? coef[r][c] * pval[ch][r][c] : 17'sd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            acc[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    acc[ch] = acc[ch] + 21'(r_prod[ch][r][c]);
                end
            end
            if (acc[ch][20]) begin
                o_chan[ch] = 8'd0;
            end else if (acc[ch][19:14] != 6'd0) begin
                o_chan[ch] = 8'd255;
            end else begin
                o_chan[ch] = acc[ch][13:6];
            end
        end
    end

endmodule

// ----- rtl/rgb_conv3x3_zero_pad_core.sv -----
// Top level of the streaming 3x3 RGB convolution filter with zero padding.
// Depends on rgbc3_pkg, rgbc3_line_mem and rgbc3_filter.
//
// Pixels enter on the input channel (i_in_valid, o_in_stall, i_in_data) in
// raster order, top row first. Results leave on the output channel
// (o_out_valid, i_out_stall, o_out_data), one filtered pixel per pixel in.
// The result for a pixel is released by the beat that comes one row plus one
// pixel after it, so after the last pixel of a frame the sender supplies
// width plus one drain beats; frame_end marks the last result of the frame.
// Configuration writes use i_cfg_we, i_cfg_idx and i_cfg_data; the user must
// make them only while the block is idle, as the block does not enforce this.
// One beat is taken every clock cycle while o_in_stall is low. A result
// reaches o_out_valid through the line store read, the window update, the
// product register and the output queue write of the sum, each registered.
// An eight-entry output queue absorbs receiver stalls; o_in_stall rises only
// when eight results are owed to the receiver.
// Reset sets 640 by 480 pixels, an identity kernel and an empty pipeline.
// The line store is not cleared; entries not yet written in a frame only
// reach window places that the padding masks.
module rgb_conv3x3_zero_pad_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [23:0]            i_cfg_data,
    input  logic                   i_in_valid,
    input  rgbc3_pkg::t_in_beat    i_in_data,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output rgbc3_pkg::t_out_beat   o_out_data,
    input  logic                   i_out_stall
);

    // Configuration.
    logic [10:0] r_img_w;
    logic [15:0] r_img_h;
    rgbc3_pkg::t_kernel r_kern;

    // Stream position counters.
    logic [16:0] r_in_row, n_in_row;
    logic [9:0]  r_in_col, n_in_col;
    logic [15:0] r_out_row, n_out_row;
    logic [9:0]  r_out_col, n_out_col;

    // Acceptance-cycle logic.
    logic        accept;
    logic [10:0] w_eff;
    logic [15:0] h_eff;
    logic        restart;
    logic [16:0] b_in_row;
    logic [9:0]  b_in_col;
    logic [15:0] b_out_row;
    logic [9:0]  b_out_col;
    logic        in_live;
    logic        push;
    rgbc3_pkg::t_pix pix;
    logic [10:0] col_inc;
    logic [16:0] p_in_row;
    logic [9:0]  p_in_col;
    logic signed [17:0] row_diff;
    logic signed [11:0] col_diff;
    logic signed [29:0] row_prod;
    logic signed [30:0] diff;
    logic [11:0] w_p1;
    logic        res;
    rgbc3_pkg::t_edge edge_m;
    logic        last;
    logic [10:0] oc_inc;

    // Window stage.
    logic                  r_s1_push;
    logic                  r_s1_res;
    logic                  r_s1_last;
    rgbc3_pkg::t_edge      r_s1_edge;
    rgbc3_pkg::t_pix       r_s1_pix;
    logic [rgbc3_pkg::LINE_AW-1:0] r_s1_addr;
    rgbc3_pkg::t_line_word line_rd;
    rgbc3_pkg::t_line_word line_wr;
    rgbc3_pkg::t_window    r_win;

    // Product and sum stages.
    logic                  r_s2_res;
    logic                  r_s2_last;
    rgbc3_pkg::t_edge      r_s2_edge;
    logic                  r_s3_res;
    logic                  r_s3_last;
    logic [2:0][7:0]       chan;

    // Output queue.
    rgbc3_pkg::t_out_beat  r_fifo [rgbc3_pkg::FIFO_DEPTH];
    rgbc3_pkg::t_out_beat  fifo_wr;
    logic [rgbc3_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [rgbc3_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [rgbc3_pkg::FIFO_AW:0]   r_fcnt;
    logic [rgbc3_pkg::FIFO_AW:0]   r_pend;
    logic                          take;

    assign o_in_stall  = (r_pend == (rgbc3_pkg::FIFO_AW+1)'(rgbc3_pkg::FIFO_DEPTH));
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_fcnt != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];
    assign take        = o_out_valid && !i_out_stall;

    always_comb begin
        if (r_img_w == 11'd0) begin
            w_eff = 11'd1;
        end else if (r_img_w > 11'(rgbc3_pkg::MAX_WIDTH)) begin
            w_eff = 11'(rgbc3_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_img_w;
        end
        h_eff = (r_img_h == 16'd0) ? 16'd1 : r_img_h;

        restart   = (r_out_row >= h_eff);
        b_in_row  = restart ? '0 : r_in_row;
        b_in_col  = restart ? '0 : r_in_col;
        b_out_row = restart ? '0 : r_out_row;
        b_out_col = restart ? '0 : r_out_col;

        in_live = (b_in_row < {1'b0, h_eff});
        push    = accept && !(in_live && i_in_data.kind);
        pix     = in_live ? {i_in_data.blue_in, i_in_data.green_in, i_in_data.red_in} : '0;

        col_inc = {1'b0, b_in_col} + 11'd1;
        if (col_inc >= w_eff) begin
            p_in_col = '0;
            p_in_row = b_in_row + 17'd1;
        end else begin
            p_in_col = col_inc[9:0];
            p_in_row = b_in_row;
        end

        row_diff = $signed({1'b0, p_in_row}) - $signed({2'b0, b_out_row});
        col_diff = $signed({2'b0, p_in_col}) - $signed({2'b0, b_out_col});
        row_prod = 30'(row_diff * $signed({1'b0, w_eff}));
        diff     = 31'(row_prod) + 31'(col_diff);
        w_p1     = {1'b0, w_eff} + 12'd1;
        res      = push && (diff > $signed({19'd0, w_p1}));

        edge_m.top    = (b_out_row != 16'd0);
        edge_m.bottom = (({1'b0, b_out_row} + 17'd1) < {1'b0, h_eff});
        edge_m.left   = (b_out_col != 10'd0);
        edge_m.right  = (({1'b0, b_out_col} + 11'd1) < w_eff);
        last          = !edge_m.right && !edge_m.bottom;

        oc_inc = {1'b0, b_out_col} + 11'd1;

        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        if (accept) begin
            if (res && last) begin
                n_in_row  = '0;
                n_in_col  = '0;
                n_out_row = '0;
                n_out_col = '0;
            end else begin
                n_in_row  = push ? p_in_row : b_in_row;
                n_in_col  = push ? p_in_col : b_in_col;
                n_out_row = b_out_row;
                n_out_col = b_out_col;
                if (res) begin
                    if (oc_inc >= w_eff) begin
                        n_out_col = '0;
                        n_out_row = b_out_row + 16'd1;
                    end else begin
                        n_out_col = oc_inc[9:0];
                    end
                end
            end
        end
    end

    rgbc3_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (b_in_col),
        .i_wr_en   (r_s1_push),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (line_wr),
        .o_rd_data (line_rd)
    );

    assign line_wr.older = line_rd.newer;
    assign line_wr.newer = r_s1_pix;

    rgbc3_filter u_filter (
        .i_clk  (i_clk),
        .i_win  (r_win),
        .i_kern (r_kern),
        .i_edge (r_s2_edge),
        .o_chan (chan)
    );

    assign fifo_wr.red_out   = chan[0];
    assign fifo_wr.green_out = chan[1];
    assign fifo_wr.blue_out  = chan[2];
    assign fifo_wr.frame_end = r_s3_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w   <= rgbc3_pkg::RST_IMAGE_WIDTH;
            r_img_h   <= rgbc3_pkg::RST_IMAGE_HEIGHT;
            r_kern[0] <= rgbc3_pkg::RST_KERNEL_TOP;
            r_kern[1] <= rgbc3_pkg::RST_KERNEL_MIDDLE;
            r_kern[2] <= rgbc3_pkg::RST_KERNEL_BOTTOM;
        end else if (i_cfg_we) begin
            unique case (rgbc3_pkg::t_cfg_idx'(i_cfg_idx))
                rgbc3_pkg::CFG_IMAGE_WIDTH:   r_img_w   <= i_cfg_data[10:0];
                rgbc3_pkg::CFG_IMAGE_HEIGHT:  r_img_h   <= i_cfg_data[15:0];
                rgbc3_pkg::CFG_KERNEL_TOP:    r_kern[0] <= i_cfg_data;
                rgbc3_pkg::CFG_KERNEL_MIDDLE: r_kern[1] <= i_cfg_data;
                rgbc3_pkg::CFG_KERNEL_BOTTOM: r_kern[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_s1_push <= 1'b0;
            r_s1_res  <= 1'b0;
            r_s2_res  <= 1'b0;
            r_s3_res  <= 1'b0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_fcnt    <= '0;
            r_pend    <= '0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_s1_push <= push;
            r_s1_res  <= res;
            r_s2_res  <= r_s1_res;
            r_s3_res  <= r_s2_res;
            if (r_s3_res) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fcnt <= r_fcnt + (rgbc3_pkg::FIFO_AW+1)'(r_s3_res)
                             - (rgbc3_pkg::FIFO_AW+1)'(take);
            r_pend <= r_pend + (rgbc3_pkg::FIFO_AW+1)'(res)
                             - (rgbc3_pkg::FIFO_AW+1)'(take);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= last;
        r_s1_edge <= edge_m;
        r_s1_pix  <= pix;
        r_s1_addr <= b_in_col;
        r_s2_last <= r_s1_last;
        r_s2_edge <= r_s1_edge;
        r_s3_last <= r_s2_last;
        if (r_s1_push) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= line_rd.older;
            r_win[1][2] <= line_rd.newer;
            r_win[2][2] <= r_s1_pix;
        end
        if (r_s3_res) begin
            r_fifo[r_wr_ptr] <= fifo_wr;
        end
    end

endmodule
